FILE: hdl/bba_pkg.sv
package bba_pkg;

    localparam int DEF_ARENA_ORDER = 16;
    localparam int DEF_UNIT_ORDER  = 4;

    // Fixed widths of the external fields.
    localparam int ORD_W   = 5;
    localparam int SIZE_W  = 17;
    localparam int OFF_W   = 16;
    localparam int HDR_W   = 6;
    localparam int HDR_FREE_BIT = 5;

    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_SPACE  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_MIN_ORDER = 2'd0,
        REG_MAX_ORDER = 2'd1,
        REG_HEAP_SIZE = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CLEAR,
        S_CARVE,
        S_PUSH_A,
        S_PUSH_B,
        S_RM_RD,
        S_RM_A,
        S_RM_B,
        S_RM_C,
        S_SPLIT,
        S_FR_HDR,
        S_FR_LOOP,
        S_FR_CHK,
        S_FIN
    } state_t;

    typedef struct packed {
        status_t            status;
        logic [OFF_W-1:0]   offset;
        logic [ORD_W-1:0]   order;
    } bba_result_t;

    typedef struct packed {
        logic hdr;
        logic next;
        logic prev;
    } bba_wr_en_t;

    // Order of the smallest power of two that holds size bytes, no lower than lo.
    function automatic logic [ORD_W-1:0] size_order(input logic [SIZE_W-1:0] size,
                                                    input logic [ORD_W-1:0] lo);
        logic [SIZE_W-1:0] v;
        logic [ORD_W-1:0]  o;
        v = (size == '0) ? '0 : size - SIZE_W'(1);
        o = '0;
        for (int i = 0; i < SIZE_W; i++)
        begin
            if (v[i])
                o = ORD_W'(i + 1);
        end
        return (o < lo) ? lo : o;
    endfunction

endpackage

FILE: hdl/bba_mem.sv
module bba_mem
    import bba_pkg::*;
#(
    parameter int UW = DEF_ARENA_ORDER - DEF_UNIT_ORDER
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [UW-1:0] rd_addr,
    output logic [HDR_W-1:0] rd_hdr,
    output logic [UW:0]   rd_next,
    output logic [UW:0]   rd_prev,
    input  bba_wr_en_t    wr_en,
    input  logic [UW-1:0] wr_addr,
    input  logic [HDR_W-1:0] wr_hdr,
    input  logic [UW:0]   wr_next,
    input  logic [UW:0]   wr_prev
);

    localparam int LW    = UW + 1;
    localparam int DW    = HDR_W + 2 * LW;
    localparam int DEPTH = 1 << UW;

    // One entry per unit: header, next link, previous link; each field written on its own.
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en.hdr)
            mem[wr_addr][DW-1 -: HDR_W] <= wr_hdr;
        if (wr_en.next)
            mem[wr_addr][2*LW-1 -: LW] <= wr_next;
        if (wr_en.prev)
            mem[wr_addr][LW-1:0] <= wr_prev;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_hdr  = rd_data_reg[DW-1 -: HDR_W];
    assign rd_next = rd_data_reg[2*LW-1 -: LW];
    assign rd_prev = rd_data_reg[LW-1:0];

endmodule

FILE: hdl/bba_seq.sv
module bba_seq
    import bba_pkg::*;
#(
    parameter int ARENA_ORDER = DEF_ARENA_ORDER,
    parameter int UNIT_ORDER  = DEF_UNIT_ORDER
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  action_t           act,
    input  logic [SIZE_W-1:0] size,
    input  logic [OFF_W-1:0]  offset,
    input  logic [ORD_W-1:0]  min_ord,
    input  logic [ORD_W-1:0]  max_ord,
    input  logic [SIZE_W-1:0] heap_bytes,
    output logic              busy,
    output logic              res_valid,
    output bba_result_t       res,
    input  logic              res_take
);

    localparam int UW   = ARENA_ORDER - UNIT_ORDER;
    localparam int LW   = UW + 1;
    localparam int NORD = ARENA_ORDER + 1;
    localparam int OIW  = $clog2(NORD);
    localparam int EW   = ARENA_ORDER + 1;
    localparam int OFFW = (ARENA_ORDER > OFF_W) ? ARENA_ORDER : OFF_W;
    localparam logic [LW-1:0] NIL = LW'(1) << UW;

    state_t            state_reg, state_next;
    action_t           op_reg, op_next;
    logic [ORD_W-1:0]  need_reg, need_next;
    logic [ORD_W-1:0]  o_reg, o_next;
    logic [UW-1:0]     u_reg, u_next;
    logic [UW-1:0]     blk_reg, blk_next;
    logic [UW-1:0]     sweep_reg, sweep_next;
    logic [OFFW-1:0]   off_reg, off_next;
    logic [EW-1:0]     cur_reg, cur_next;
    logic [LW-1:0]     h_reg, h_next;
    logic [ORD_W-1:0]  lat_min_reg, lat_min_next;
    logic [ORD_W-1:0]  lat_max_reg, lat_max_next;
    logic [EW-1:0]     lat_end_reg, lat_end_next;
    logic [LW-1:0]     heads_reg [NORD];
    logic [LW-1:0]     heads_next [NORD];
    logic [NORD-1:0]   avail_reg, avail_next;
    bba_result_t       res_reg, res_next;

    logic              rd_en;
    logic [UW-1:0]     rd_addr;
    logic [HDR_W-1:0]  rd_hdr;
    logic [LW-1:0]     rd_next;
    logic [LW-1:0]     rd_prev;
    bba_wr_en_t        wr_en;
    logic [UW-1:0]     wr_addr;
    logic [HDR_W-1:0]  wr_hdr;
    logic [LW-1:0]     wr_next;
    logic [LW-1:0]     wr_prev;

    logic [ORD_W-1:0]  find_ord;
    logic              find_any;
    logic [EW-1:0]     carve_rem;
    logic [ORD_W-1:0]  carve_msb;
    logic [ORD_W-1:0]  carve_k;
    logic [LW-1:0]     head_at_o;
    logic [UW-1:0]     off_unit;

    bba_mem #(.UW(UW)) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_hdr  (rd_hdr),
        .rd_next (rd_next),
        .rd_prev (rd_prev),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_hdr  (wr_hdr),
        .wr_next (wr_next),
        .wr_prev (wr_prev)
    );

    // Smallest available order at or above the one needed.
    always_comb
    begin
        find_ord = '0;
        find_any = 1'b0;
        for (int i = NORD - 1; i >= 0; i--)
        begin
            if (avail_reg[i] && (i >= int'(need_reg)))
            begin
                find_ord = ORD_W'(i);
                find_any = 1'b1;
            end
        end
    end

    // Largest block that fits the rest of the heap, capped at the top order.
    assign carve_rem = lat_end_reg - cur_reg;

    always_comb
    begin
        carve_msb = '0;
        for (int i = 0; i < EW; i++)
        begin
            if (carve_rem[i])
                carve_msb = ORD_W'(i);
        end
    end

    assign carve_k   = (carve_msb > lat_max_reg) ? lat_max_reg : carve_msb;
    assign head_at_o = heads_reg[o_reg[OIW-1:0]];
    assign off_unit  = off_reg[UNIT_ORDER +: UW];

    always_comb
    begin
        logic [ORD_W-1:0] lo;
        logic [ORD_W-1:0] hi;
        logic [31:0]      hs32;
        logic [31:0]      off32;
        logic [31:0]      end32;
        logic [31:0]      bud32;
        logic [LW-1:0]    hd;
        logic [ORD_W-1:0] on;
        logic             push_fin;

        state_next   = state_reg;
        op_next      = op_reg;
        need_next    = need_reg;
        o_next       = o_reg;
        u_next       = u_reg;
        blk_next     = blk_reg;
        sweep_next   = sweep_reg;
        off_next     = off_reg;
        cur_next     = cur_reg;
        h_next       = h_reg;
        lat_min_next = lat_min_reg;
        lat_max_next = lat_max_reg;
        lat_end_next = lat_end_reg;
        heads_next   = heads_reg;
        avail_next   = avail_reg;
        res_next     = res_reg;

        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = '0;
        wr_addr  = '0;
        wr_hdr   = '0;
        wr_next  = '0;
        wr_prev  = '0;
        res_valid = 1'b0;
        push_fin = 1'b0;

        lo    = '0;
        hi    = '0;
        hs32  = '0;
        off32 = 32'(off_reg);
        end32 = 32'(lat_end_reg);
        bud32 = off32 ^ (32'd1 << o_reg);
        hd    = '0;
        on    = o_reg - ORD_W'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = act;
                    need_next  = size_order(size, lat_min_reg);
                    off_next   = OFFW'(offset);
                    res_next   = '0;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                unique case (op_reg)
                    ACT_INIT:
                    begin
                        lo = min_ord;
                        if (lo < ORD_W'(UNIT_ORDER))
                            lo = ORD_W'(UNIT_ORDER);
                        if (lo > ORD_W'(ARENA_ORDER))
                            lo = ORD_W'(ARENA_ORDER);
                        hi = max_ord;
                        if (hi < lo)
                            hi = lo;
                        if (hi > ORD_W'(ARENA_ORDER))
                            hi = ORD_W'(ARENA_ORDER);
                        hs32 = 32'(heap_bytes);
                        if (hs32 > (32'd1 << ARENA_ORDER))
                            hs32 = 32'd1 << ARENA_ORDER;
                        hs32 = hs32 & ~((32'd1 << lo) - 32'd1);
                        lat_min_next = lo;
                        lat_max_next = hi;
                        lat_end_next = EW'(hs32);
                        for (int i = 0; i < NORD; i++)
                            heads_next[i] = NIL;
                        avail_next = '0;
                        sweep_next = '0;
                        state_next = S_CLEAR;
                    end
                    ACT_ALLOC:
                    begin
                        hd = heads_reg[find_ord[OIW-1:0]];
                        if (need_reg > lat_max_reg)
                        begin
                            res_next.status = ST_TOO_LARGE;
                            state_next = S_FIN;
                        end
                        else if (!find_any || hd == NIL)
                        begin
                            res_next.status = ST_NO_SPACE;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            o_next     = find_ord;
                            u_next     = hd[UW-1:0];
                            blk_next   = hd[UW-1:0];
                            state_next = S_RM_RD;
                        end
                    end
                    ACT_FREE:
                    begin
                        if (need_reg > lat_max_reg)
                        begin
                            res_next.status = ST_TOO_LARGE;
                            state_next = S_FIN;
                        end
                        else if ((off32 & ((32'd1 << need_reg) - 32'd1)) != '0 ||
                                 (off32 + (32'd1 << need_reg)) > end32)
                        begin
                            res_next.status = ST_NO_SPACE;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = off_unit;
                            o_next     = need_reg;
                            state_next = S_FR_HDR;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            // Init wipes every header, one unit a cycle.
            S_CLEAR:
            begin
                wr_en.hdr  = 1'b1;
                wr_addr    = sweep_reg;
                wr_hdr     = '0;
                sweep_next = sweep_reg + UW'(1);
                if (sweep_reg == '1)
                begin
                    cur_next   = '0;
                    state_next = S_CARVE;
                end
            end

            S_CARVE:
            begin
                if (cur_reg < lat_end_reg)
                begin
                    o_next     = carve_k;
                    u_next     = cur_reg[UNIT_ORDER +: UW];
                    state_next = S_PUSH_A;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_PUSH_A:
            begin
                wr_en   = '{hdr: 1'b1, next: 1'b1, prev: 1'b1};
                wr_addr = u_reg;
                wr_hdr  = {1'b1, o_reg};
                wr_next = head_at_o;
                wr_prev = NIL;
                heads_next[o_reg[OIW-1:0]] = {1'b0, u_reg};
                avail_next[o_reg[OIW-1:0]] = 1'b1;
                h_next = head_at_o;
                if (head_at_o != NIL)
                    state_next = S_PUSH_B;
                else
                    push_fin = 1'b1;
            end

            S_PUSH_B:
            begin
                wr_en.prev = 1'b1;
                wr_addr    = h_reg[UW-1:0];
                wr_prev    = {1'b0, u_reg};
                push_fin   = 1'b1;
            end

            S_RM_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = u_reg;
                state_next = S_RM_A;
            end

            // The read data stays put until the next read, so RM_B may use it too.
            S_RM_A:
            begin
                if (rd_prev != NIL)
                begin
                    wr_en.next = 1'b1;
                    wr_addr    = rd_prev[UW-1:0];
                    wr_next    = rd_next;
                end
                else
                begin
                    heads_next[o_reg[OIW-1:0]] = rd_next;
                end
                state_next = (rd_next != NIL) ? S_RM_B : S_RM_C;
            end

            S_RM_B:
            begin
                wr_en.prev = 1'b1;
                wr_addr    = rd_next[UW-1:0];
                wr_prev    = rd_prev;
                state_next = S_RM_C;
            end

            S_RM_C:
            begin
                wr_en.hdr = 1'b1;
                wr_addr   = u_reg;
                wr_hdr    = '0;
                if (head_at_o == NIL)
                    avail_next[o_reg[OIW-1:0]] = 1'b0;
                if (op_reg == ACT_FREE)
                begin
                    off_next   = off_reg & ~(OFFW'(1) << o_reg);
                    o_next     = o_reg + ORD_W'(1);
                    state_next = S_FR_LOOP;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end

            // Each split level hands the upper half back to the next lower list.
            S_SPLIT:
            begin
                if (o_reg > need_reg)
                begin
                    o_next     = on;
                    u_next     = blk_reg + (UW'(1) << (on - ORD_W'(UNIT_ORDER)));
                    state_next = S_PUSH_A;
                end
                else
                begin
                    res_next.offset = OFF_W'({blk_reg, {UNIT_ORDER{1'b0}}});
                    res_next.order  = need_reg;
                    state_next      = S_FIN;
                end
            end

            S_FR_HDR:
            begin
                if (rd_hdr[HDR_FREE_BIT])
                begin
                    res_next.status = ST_NO_SPACE;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_FR_LOOP;
                end
            end

            S_FR_LOOP:
            begin
                if (o_reg < lat_max_reg && bud32 < end32)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = bud32[UNIT_ORDER +: UW];
                    u_next     = bud32[UNIT_ORDER +: UW];
                    state_next = S_FR_CHK;
                end
                else
                begin
                    u_next     = off_unit;
                    state_next = S_PUSH_A;
                end
            end

            S_FR_CHK:
            begin
                if (rd_hdr == {1'b1, o_reg})
                begin
                    state_next = S_RM_A;
                end
                else
                begin
                    u_next     = off_unit;
                    state_next = S_PUSH_A;
                end
            end

            S_FIN:
            begin
                res_valid = 1'b1;
                if (res_take)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push_fin)
        begin
            unique case (op_reg)
                ACT_INIT:
                begin
                    cur_next   = cur_reg + (EW'(1) << o_reg);
                    state_next = S_CARVE;
                end
                ACT_ALLOC:
                begin
                    state_next = S_SPLIT;
                end
                default:
                begin
                    state_next = S_FIN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            lat_min_reg <= ORD_W'(4);
            lat_max_reg <= ORD_W'(16);
            lat_end_reg <= '0;
            avail_reg   <= '0;
            for (int i = 0; i < NORD; i++)
                heads_reg[i] <= NIL;
        end
        else
        begin
            state_reg   <= state_next;
            lat_min_reg <= lat_min_next;
            lat_max_reg <= lat_max_next;
            lat_end_reg <= lat_end_next;
            avail_reg   <= avail_next;
            heads_reg   <= heads_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        need_reg  <= need_next;
        o_reg     <= o_next;
        u_reg     <= u_next;
        blk_reg   <= blk_next;
        sweep_reg <= sweep_next;
        off_reg   <= off_next;
        cur_reg   <= cur_next;
        h_reg     <= h_next;
        res_reg   <= res_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign res  = res_reg;

`ifndef SYNTHESIS
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !((wr_en.hdr || wr_en.next || wr_en.prev) && wr_addr == rd_addr))
        else $error("read and write of the same entry in one cycle");

    a_end_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (lat_end_reg & ((EW'(1) << lat_min_reg) - EW'(1))) == '0 &&
        lat_end_reg <= (EW'(1) << ARENA_ORDER))
        else $error("latched heap end not aligned to the smallest block");

    a_orders_latched: assert property (@(posedge clk) disable iff (!rst_n)
        lat_min_reg <= lat_max_reg && lat_max_reg <= ORD_W'(ARENA_ORDER))
        else $error("latched orders out of range");
`endif

endmodule

FILE: hdl/buddy_block_allocator_top.sv
// Channel   Handshake            Payload
// in        in_valid / in_stall  action, request_size, block_offset
// out       out_valid / out_stall status, granted_offset, granted_order
// cfg       cfg_write            cfg_index, cfg_data
//
// One item at a time; each item gives one result transfer.
// Allocate: splits level by level, at most one memory access per cycle.
// Free: merges with free buddies one level at a time.
// Init: clears the header of every unit, then carves the heap into blocks.
// Reset empties the lists but leaves the block headers; only an init wipes them all.
// A finished result is held in the output register while the next item is taken.
module buddy_block_allocator_top
    import bba_pkg::*;
#(
    parameter int ARENA_ORDER = DEF_ARENA_ORDER,
    parameter int UNIT_ORDER  = DEF_UNIT_ORDER
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        action,
    input  logic [SIZE_W-1:0] request_size,
    input  logic [OFF_W-1:0]  block_offset,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [OFF_W-1:0]  granted_offset,
    output logic [ORD_W-1:0]  granted_order
);

    logic [ORD_W-1:0]  min_ord_reg;
    logic [ORD_W-1:0]  max_ord_reg;
    logic [SIZE_W-1:0] heap_bytes_reg;
    logic              out_valid_reg, out_valid_next;
    bba_result_t       out_reg;
    logic              busy;
    logic              res_valid;
    logic              res_take;
    bba_result_t       res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_ord_reg    <= ORD_W'(4);
            max_ord_reg    <= ORD_W'(16);
            heap_bytes_reg <= SIZE_W'(65536);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_ORDER: min_ord_reg <= cfg_data[ORD_W-1:0];
                REG_MAX_ORDER: max_ord_reg <= cfg_data[ORD_W-1:0];
                REG_HEAP_SIZE: heap_bytes_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    bba_seq #(
        .ARENA_ORDER (ARENA_ORDER),
        .UNIT_ORDER  (UNIT_ORDER)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_valid && !in_stall),
        .act        (action_t'(action)),
        .size       (request_size),
        .offset     (block_offset),
        .min_ord    (min_ord_reg),
        .max_ord    (max_ord_reg),
        .heap_bytes (heap_bytes_reg),
        .busy       (busy),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take)
    );

    // The output register takes a new result when empty or when its transfer completes.
    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
            out_reg <= res;
    end

    assign in_stall       = busy;
    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign granted_offset = out_reg.offset;
    assign granted_order  = out_reg.order;

endmodule
